/* hdl/bsd_pkg.sv */
`default_nettype none

package bsd_pkg;

    // Table size and name length limit
    localparam int TABLE_DEPTH = 128;
    localparam int NAME_LIMIT  = 100;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    // Fill count holds 0 .. TABLE_DEPTH
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    // Structure start offset may reach one past the last data byte
    localparam int START_W = LEN_W + 1;

    // Item opcodes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    // Advertising structure types that carry a device name
    localparam logic [BYTE_W-1:0] TYPE_NAME_SHORT    = 8'h08;
    localparam logic [BYTE_W-1:0] TYPE_NAME_COMPLETE = 8'h09;

    // Search wavefront passed from cell to cell
    typedef struct packed {
        logic probe;
        logic hit;
    } bsd_wave_t;

endpackage

`default_nettype wire

/* hdl/bsd_if.sv */
`default_nettype none

interface bsd_in_if import bsd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] device_address;
    logic [LEN_W-1:0]  adv_length;
    logic [BYTE_W-1:0] data_byte;

    modport source (
        output valid, opcode, device_address, adv_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, device_address, adv_length, data_byte,
        output ready
    );
endinterface

interface bsd_out_if import bsd_pkg::*;;
    logic               valid;
    logic               ready;
    logic               is_new;
    logic               has_name;
    logic               stored;
    logic [COUNT_W-1:0] device_count;
    logic [COUNT_W-1:0] named_count;

    modport source (
        output valid, is_new, has_name, stored, device_count, named_count,
        input  ready
    );
    modport sink (
        input  valid, is_new, has_name, stored, device_count, named_count,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/bsd_cell.sv */
`default_nettype none

module bsd_cell import bsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] key,
    input  wire logic              shift_en,
    input  wire logic [ADDR_W-1:0] shift_in,
    input  wire logic              occupied,
    input  wire bsd_wave_t         wave_in,
    output bsd_wave_t              wave_out,
    output logic      [ADDR_W-1:0] entry_out
);

    logic [ADDR_W-1:0] entry_reg;
    logic [ADDR_W-1:0] entry_next;
    bsd_wave_t         wave_reg;
    bsd_wave_t         wave_next;

    always_comb
    begin
        entry_next = shift_en ? shift_in : entry_reg;
        wave_next.probe = wave_in.probe;
        wave_next.hit   = wave_in.hit
                        | (wave_in.probe & occupied & (entry_reg == key));
    end

    // Entry is payload: no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave_out  = wave_reg;
    assign entry_out = entry_reg;

endmodule

`default_nettype wire

/* hdl/bsd_chain.sv */
`default_nettype none

module bsd_chain import bsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] key,
    input  wire logic              launch,
    input  wire logic              shift_en,
    input  wire logic [ADDR_W-1:0] shift_addr,
    input  wire logic [USED_W-1:0] used,
    output bsd_wave_t              wave_out
);

    bsd_wave_t         wave  [TABLE_DEPTH+1];
    logic [ADDR_W-1:0] entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occupied;

    // Inject the probe at the head of the row
    assign wave[0].probe = launch;
    assign wave[0].hit   = 1'b0;

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            logic [ADDR_W-1:0] shift_src;

            // Newest address enters at cell 0, older ones move one cell down
            if (i == 0)
            begin : g_head
                assign shift_src = shift_addr;
            end
            else
            begin : g_body
                assign shift_src = entry[i-1];
            end

            assign occupied[i] = (used > USED_W'(i));

            bsd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .key       (key),
                .shift_en  (shift_en),
                .shift_in  (shift_src),
                .occupied  (occupied[i]),
                .wave_in   (wave[i]),
                .wave_out  (wave[i+1]),
                .entry_out (entry[i])
            );
        end
    endgenerate

    assign wave_out = wave[TABLE_DEPTH];

endmodule

`default_nettype wire

/* hdl/ble_scan_dedup_name_detect.sv */
`default_nettype none

// BLE scan report deduplicator with advertising-name detection. A report is a
// header transaction (opcode 0: device address and data length) followed by
// that many data-byte transactions (opcode 1). The header is looked up in a
// table of TABLE_DEPTH addresses held in a row of cells; a probe walks down
// the row one cell per clock, and no further transaction is taken until the
// probe has left the last cell and the result slot is free. A data byte is
// walked in the cycle it is taken. New addresses are stored while room
// remains; the device count is bumped for every new address even when the
// table is full. Exactly one result per report that is not abandoned: at the
// end of the header search for a known device or empty data, otherwise with
// the last data byte. Data bytes of known devices and stray bytes outside a
// report are dropped without a result. A header arriving mid-report abandons
// the open report. The table needs no clearing after reset: only cells below
// the fill count take part in a search.
module ble_scan_dedup_name_detect import bsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bsd_in_if.sink    scan_in,
    bsd_out_if.source result_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_LEN,
        P_TYPE,
        P_DONE
    } parse_phase_t;

    ctl_state_t   ctl_reg,   ctl_next;
    parse_phase_t phase_reg, phase_next;

    // Search context
    logic [ADDR_W-1:0] key_reg,     key_next;
    logic [LEN_W-1:0]  hdr_len_reg, hdr_len_next;
    logic              launch_reg,  launch_next;
    logic              hit_reg,     hit_next;

    // Table fill count and running totals
    logic [USED_W-1:0]  used_reg,        used_next;
    logic [COUNT_W-1:0] dev_total_reg,   dev_total_next;
    logic [COUNT_W-1:0] named_total_reg, named_total_next;

    // Advertising data walk
    logic [LEN_W-1:0]   bpos_reg,   bpos_next;
    logic [START_W-1:0] start_reg,  start_next;
    logic [LEN_W-1:0]   clen_reg,   clen_next;
    logic [LEN_W-1:0]   rlen_reg,   rlen_next;
    logic               named_reg,  named_next;
    logic               stflag_reg, stflag_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               is_new_reg,    is_new_next;
    logic               has_name_reg,  has_name_next;
    logic               stored_reg,    stored_next;
    logic [COUNT_W-1:0] dev_cnt_reg,   dev_cnt_next;
    logic [COUNT_W-1:0] named_cnt_reg, named_cnt_next;

    logic      accept;
    logic      slot_free;
    logic      shift_en;
    logic      room;
    bsd_wave_t chain_wave;

    // Walk scratch values
    logic [BYTE_W+1:0] end_sum;
    logic              walk_end;

    // A result slot is free when empty or being drained this cycle
    assign slot_free       = !out_valid_reg || result_out.ready;
    assign scan_in.ready   = (ctl_reg == S_IDLE) && slot_free;
    assign accept          = scan_in.valid && scan_in.ready;
    assign room            = (used_reg < USED_W'(TABLE_DEPTH));

    bsd_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_reg),
        .launch     (launch_reg),
        .shift_en   (shift_en),
        .shift_addr (key_reg),
        .used       (used_reg),
        .wave_out   (chain_wave)
    );

    always_comb
    begin
        ctl_next         = ctl_reg;
        phase_next       = phase_reg;
        key_next         = key_reg;
        hdr_len_next     = hdr_len_reg;
        launch_next      = 1'b0;
        hit_next         = hit_reg;
        used_next        = used_reg;
        dev_total_next   = dev_total_reg;
        named_total_next = named_total_reg;
        bpos_next        = bpos_reg;
        start_next       = start_reg;
        clen_next        = clen_reg;
        rlen_next        = rlen_reg;
        named_next       = named_reg;
        stflag_next      = stflag_reg;
        shift_en         = 1'b0;

        // Drop the result once taken
        out_valid_next = out_valid_reg && !result_out.ready;
        is_new_next    = is_new_reg;
        has_name_next  = has_name_reg;
        stored_next    = stored_reg;
        dev_cnt_next   = dev_cnt_reg;
        named_cnt_next = named_cnt_reg;

        end_sum  = {3'b000, start_reg} + {2'b00, scan_in.data_byte};
        walk_end = ({1'b0, bpos_reg} + 7'd1) >= {1'b0, rlen_reg};

        case (ctl_reg)
            S_IDLE:
            begin
                if (accept && scan_in.opcode == OP_HEADER)
                begin
                    // Abandon any open report and start the table search
                    phase_next   = P_IDLE;
                    key_next     = scan_in.device_address;
                    hdr_len_next = scan_in.adv_length;
                    launch_next  = 1'b1;
                    ctl_next     = S_SEARCH;
                end
                else if (accept && phase_reg != P_IDLE)
                begin
                    case (phase_reg)
                        P_LEN:
                        begin
                            if ({1'b0, bpos_reg} == start_reg)
                            begin
                                if (scan_in.data_byte == '0
                                    || end_sum > {4'b0000, rlen_reg})
                                begin
                                    phase_next = P_DONE;
                                end
                                else
                                begin
                                    clen_next  = scan_in.data_byte[LEN_W-1:0];
                                    phase_next = P_TYPE;
                                end
                            end
                        end
                        P_TYPE:
                        begin
                            if (scan_in.data_byte == TYPE_NAME_SHORT
                                || scan_in.data_byte == TYPE_NAME_COMPLETE)
                            begin
                                if (clen_reg > 6'd1 && int'(clen_reg) < NAME_LIMIT + 1)
                                begin
                                    named_next = 1'b1;
                                end
                                phase_next = P_DONE;
                            end
                            else
                            begin
                                start_next = start_reg + {1'b0, clen_reg} + 7'd1;
                                phase_next = P_LEN;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    if (walk_end)
                    begin
                        // Close the report with the last byte
                        named_total_next = named_total_reg + {15'd0, named_next};
                        out_valid_next   = 1'b1;
                        is_new_next      = 1'b1;
                        has_name_next    = named_next;
                        stored_next      = stflag_reg;
                        dev_cnt_next     = dev_total_reg;
                        named_cnt_next   = named_total_next;
                        phase_next       = P_IDLE;
                    end
                    else
                    begin
                        bpos_next = bpos_reg + 6'd1;
                    end
                end
            end
            S_SEARCH:
            begin
                // Hold until the probe leaves the last cell
                if (chain_wave.probe)
                begin
                    hit_next = chain_wave.hit;
                    ctl_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    ctl_next       = S_IDLE;
                    out_valid_next = hdr_len_reg == '0 || hit_reg;
                    if (hit_reg)
                    begin
                        is_new_next    = 1'b0;
                        has_name_next  = 1'b0;
                        stored_next    = 1'b0;
                        dev_cnt_next   = dev_total_reg;
                        named_cnt_next = named_total_reg;
                    end
                    else
                    begin
                        // Store while room remains, count regardless
                        shift_en       = room;
                        used_next      = used_reg + USED_W'(room);
                        dev_total_next = dev_total_reg + 16'd1;
                        stflag_next    = room;
                        is_new_next    = 1'b1;
                        has_name_next  = 1'b0;
                        stored_next    = room;
                        dev_cnt_next   = dev_total_next;
                        named_cnt_next = named_total_reg;
                        if (hdr_len_reg != '0)
                        begin
                            rlen_next  = hdr_len_reg;
                            bpos_next  = '0;
                            start_next = '0;
                            clen_next  = '0;
                            named_next = 1'b0;
                            phase_next = P_LEN;
                        end
                    end
                end
            end
            default:
            begin
                ctl_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg         <= S_IDLE;
            phase_reg       <= P_IDLE;
            launch_reg      <= 1'b0;
            used_reg        <= '0;
            dev_total_reg   <= '0;
            named_total_reg <= '0;
            bpos_reg        <= '0;
            start_reg       <= '0;
            clen_reg        <= '0;
            rlen_reg        <= '0;
            named_reg       <= 1'b0;
            stflag_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ctl_reg         <= ctl_next;
            phase_reg       <= phase_next;
            launch_reg      <= launch_next;
            used_reg        <= used_next;
            dev_total_reg   <= dev_total_next;
            named_total_reg <= named_total_next;
            bpos_reg        <= bpos_next;
            start_reg       <= start_next;
            clen_reg        <= clen_next;
            rlen_reg        <= rlen_next;
            named_reg       <= named_next;
            stflag_reg      <= stflag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        hdr_len_reg   <= hdr_len_next;
        hit_reg       <= hit_next;
        is_new_reg    <= is_new_next;
        has_name_reg  <= has_name_next;
        stored_reg    <= stored_next;
        dev_cnt_reg   <= dev_cnt_next;
        named_cnt_reg <= named_cnt_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.is_new       = is_new_reg;
    assign result_out.has_name     = has_name_reg;
    assign result_out.stored       = stored_reg;
    assign result_out.device_count = dev_cnt_reg;
    assign result_out.named_count  = named_cnt_reg;

    // The probe only leaves the row while a search is pending
    a_probe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_wave.probe |-> ctl_reg == S_SEARCH)
        else $error("probe left the cell row outside a search");

    // Never shift an address into a full table
    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> used_reg < USED_W'(TABLE_DEPTH))
        else $error("address stored into a full table");

    // A new device advances the device total by exactly one
    a_dev_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == S_COMMIT && slot_free && !hit_reg)
        |=> dev_total_reg == $past(dev_total_reg) + 16'd1)
        else $error("device total did not advance for a new device");

    // No transaction is taken while the probe is launched or leaves the row
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (launch_reg || chain_wave.probe) |-> !scan_in.ready)
        else $error("input taken during a table search");

endmodule

`default_nettype wire
